/* sv/m2d_pkg.sv */
package m2d_pkg;

  // Packet geometry of the incoming stream.
  localparam int unsigned PacketBytes = 192;
  localparam int unsigned HeaderBytes = 4;

  // Widths that follow from the packet geometry.
  localparam int unsigned PhaseW = $clog2(PacketBytes);
  localparam int unsigned FillW  = $clog2(PacketBytes + 1);

  // Configuration register map.
  localparam int unsigned PaddrW    = 3;
  localparam logic        RegSync   = 1'b0;
  localparam logic [7:0]  SyncReset = 8'h47;

  // One delivered byte with its framing flags.
  typedef struct packed {
    logic [7:0] ts_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       after_resync;
  } result_t;

endpackage

/* sv/m2d_cell.sv */
module m2d_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  // One byte of the delay line; it takes its neighbor's byte on every beat.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;

endmodule

/* sv/m2d_judge.sv */
module m2d_judge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic [7:0]         old_byte_i,
  input  logic [7:0]         sync_value_i,
  output logic               res_valid_o,
  output m2d_pkg::result_t   res_o
);

  localparam logic [m2d_pkg::PhaseW-1:0] LastPhase =
    m2d_pkg::PhaseW'(m2d_pkg::PacketBytes - 1);
  localparam logic [m2d_pkg::PhaseW-1:0] SyncPhase =
    m2d_pkg::PhaseW'(m2d_pkg::HeaderBytes);
  localparam logic [m2d_pkg::PhaseW-1:0] AfterSyncPhase =
    m2d_pkg::PhaseW'(m2d_pkg::HeaderBytes + 1);
  localparam logic [m2d_pkg::FillW-1:0] FullCount =
    m2d_pkg::FillW'(m2d_pkg::PacketBytes);

  logic [m2d_pkg::FillW-1:0]  fill_q, fill_d;
  logic [m2d_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                       hunting_q, hunting_d;
  logic                       filled;
  logic                       old_is_sync;
  logic                       new_is_sync;

  assign filled      = (fill_q == FullCount);
  assign old_is_sync = (old_byte_i == sync_value_i);
  assign new_is_sync = (in_byte_i == sync_value_i);

  // Judge the byte that leaves the delay line on this beat.
  always_comb begin
    fill_d      = fill_q;
    phase_d     = phase_q;
    hunting_d   = hunting_q;
    res_valid_o = 1'b0;
    res_o.ts_byte         = old_byte_i;
    res_o.first_of_packet = 1'b0;
    res_o.last_of_packet  = 1'b0;
    res_o.after_resync    = 1'b0;
    if (accept_i) begin
      if (!filled) begin
        fill_d = fill_q + 1'b1;
      end else if (hunting_q) begin
        // Lock where the sync value shows up twice, one packet apart.
        if (old_is_sync && new_is_sync) begin
          hunting_d   = 1'b0;
          phase_d     = AfterSyncPhase;
          res_valid_o = 1'b1;
          res_o.first_of_packet = 1'b1;
          res_o.last_of_packet  = (SyncPhase == LastPhase);
          res_o.after_resync    = 1'b1;
        end
      end else begin
        phase_d = (phase_q == LastPhase) ? '0 : phase_q + 1'b1;
        if (phase_q == SyncPhase) begin
          if (old_is_sync) begin
            res_valid_o = 1'b1;
            res_o.first_of_packet = 1'b1;
            res_o.last_of_packet  = (SyncPhase == LastPhase);
          end else begin
            // Bad sync byte: drop the packet and start hunting.
            hunting_d = 1'b1;
            phase_d   = '0;
          end
        end else if (phase_q > SyncPhase) begin
          res_valid_o = 1'b1;
          res_o.last_of_packet = (phase_q == LastPhase);
        end
      end
    end
  end

  // Framing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      phase_q   <= '0;
      hunting_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      phase_q   <= phase_d;
      hunting_q <= hunting_d;
    end
  end

endmodule

/* sv/m2ts_to_ts_deframer.sv */
// M2TS to TS deframer.
// The input channel (in_valid_i, in_ready_o, in_byte_i) takes one byte of a
// 192-byte M2TS stream per beat. The output channel (out_valid_o, out_ready_i)
// delivers the 188-byte transport packets with first, last and resync flags;
// the 4-byte header of every packet is dropped.
// Every byte passes through a row of 192 byte cells that shift on each input
// beat, so a byte is judged one packet (192 input beats) after it arrives and
// is then delivered through the output register.
// Throughput is one byte per cycle while in_ready_o is high, set by the
// shift of the cell row and the judge that looks at the cell leaving it.
// The first 192 bytes after reset only fill the row and give no output.
// A wrong sync byte drops its packet; the block then hunts for two sync
// values one packet apart and resumes there, flagging that byte after_resync.
// Reset restarts the row fill, leaves the hunt and sets sync_value to 0x47.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; in_ready_o falls only when both are full.
// sync_value is written over the APB port at addresses 0 to 3 (paddr[2] low).
module m2ts_to_ts_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   ts_byte_o,
  output logic                         first_of_packet_o,
  output logic                         last_of_packet_o,
  output logic                         after_resync_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m2d_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic             accept;
  logic [7:0]       sync_q;
  logic [7:0]       tap [m2d_pkg::PacketBytes+1];
  logic             res_valid;
  m2d_pkg::result_t res;
  logic             out_valid_q;
  m2d_pkg::result_t out_q;
  logic             skid_valid_q;
  m2d_pkg::result_t skid_q;
  logic             pop;
  logic             reg_hit;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[m2d_pkg::PaddrW-1] == m2d_pkg::RegSync);
  assign prdata  = reg_hit ? {24'd0, sync_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= m2d_pkg::SyncReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      sync_q <= pwdata[7:0];
    end
  end

  // Row of byte cells forming the one-packet delay line.
  assign tap[0] = in_byte_i;

  for (genvar k = 0; k < m2d_pkg::PacketBytes; k++) begin : g_cell
    m2d_cell u_cell (
      .clk_i (clk_i),
      .en_i  (accept),
      .d_i   (tap[k]),
      .q_o   (tap[k+1])
    );
  end

  // Framing judgment on the byte leaving the row.
  m2d_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .old_byte_i   (tap[m2d_pkg::PacketBytes]),
    .sync_value_i (sync_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Output register with a skid stage behind it.
  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ts_byte_o         = out_q.ts_byte;
  assign first_of_packet_o = out_q.first_of_packet;
  assign last_of_packet_o  = out_q.last_of_packet;
  assign after_resync_o    = out_q.after_resync;

endmodule

/* sv/m2d_checker.sv */
module m2d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic first_of_packet_o,
  input logic last_of_packet_o,
  input logic after_resync_o
);

  // A waiting result stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // A resync byte is always the sync byte of a packet.
  a_resync_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && after_resync_o |-> first_of_packet_o)
    else $error("after_resync without first_of_packet");

  // The sync byte never closes a packet.
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(first_of_packet_o && last_of_packet_o))
    else $error("byte flagged both first and last");

  // Input backpressure only arises while a result is waiting.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with the output empty");

endmodule

bind m2ts_to_ts_deframer m2d_checker u_m2d_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .first_of_packet_o (first_of_packet_o),
  .last_of_packet_o  (last_of_packet_o),
  .after_resync_o    (after_resync_o)
);
